/* rtl/joint_pd_torque_loop_macros.svh */
// Assertion macros for the joint PD torque loop.
`ifndef JOINT_PD_TORQUE_LOOP_MACROS_SVH
`define JOINT_PD_TORQUE_LOOP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define JPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define JPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/jpd_pkg.sv */
// Shared types, constants and microcode program of the joint PD torque loop.
package jpd_pkg;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIMITS_ENABLED = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_POS_LOWER      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_POS_UPPER      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEL_LIMIT      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_EFFORT_LIMIT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_PERIOD     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_POS_STOP_CODE  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_VEL_STOP_CODE  = 3'd7;

    // Microprogram step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_WAIT     = 4'd0;
    localparam logic [STEP_W-1:0] ST_VEL_DIFF = 4'd1;
    localparam logic [STEP_W-1:0] ST_VEL_MUL  = 4'd2;
    localparam logic [STEP_W-1:0] ST_VEL_RND  = 4'd3;
    localparam logic [STEP_W-1:0] ST_POS_MUL  = 4'd4;
    localparam logic [STEP_W-1:0] ST_POS_RND  = 4'd5;
    localparam logic [STEP_W-1:0] ST_DMP_MUL  = 4'd6;
    localparam logic [STEP_W-1:0] ST_DMP_RND  = 4'd7;
    localparam logic [STEP_W-1:0] ST_OUT      = 4'd8;

    typedef enum logic [1:0] {
        DIFF_NONE,
        DIFF_VEL,
        DIFF_POS,
        DIFF_DAMP
    } diff_sel_t;

    typedef enum logic [1:0] {
        RND_NONE,
        RND_VEL,
        RND_LOAD,
        RND_ADD
    } rnd_op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_NO_CMD,
        COND_RSP_BUSY
    } cond_t;

    typedef struct packed {
        logic              take_cmd;
        diff_sel_t         diff_sel;
        logic              mul_en;
        rnd_op_t           rnd_op;
        logic              put_rsp;
        cond_t             cond;
        logic              jump;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        take_cmd: 1'b0, diff_sel: DIFF_NONE, mul_en: 1'b0, rnd_op: RND_NONE,
        put_rsp: 1'b0, cond: COND_NONE, jump: 1'b0, target: ST_WAIT
    };

    // Control store: hold on the condition, else jump or advance.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = CTRL_NOP;
        case (step)
            ST_WAIT:
            begin
                w.take_cmd = 1'b1;
                w.cond     = COND_NO_CMD;
            end
            ST_VEL_DIFF: w.diff_sel = DIFF_VEL;
            ST_VEL_MUL:  w.mul_en   = 1'b1;
            ST_VEL_RND:
            begin
                w.rnd_op   = RND_VEL;
                w.diff_sel = DIFF_POS;
            end
            ST_POS_MUL:  w.mul_en   = 1'b1;
            ST_POS_RND:
            begin
                w.rnd_op   = RND_LOAD;
                w.diff_sel = DIFF_DAMP;
            end
            ST_DMP_MUL:  w.mul_en   = 1'b1;
            ST_DMP_RND:  w.rnd_op   = RND_ADD;
            ST_OUT:
            begin
                w.put_rsp = 1'b1;
                w.cond    = COND_RSP_BUSY;
                w.jump    = 1'b1;
                w.target  = ST_WAIT;
            end
            default:
            begin
                w.jump   = 1'b1;
                w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/jpd_cmd_if.sv */
// Command channel: measured position and the set point of one control tick.
interface jpd_cmd_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] measured_pos;
    logic signed [DATA_WIDTH-1:0] target_pos;
    logic signed [DATA_WIDTH-1:0] target_vel;
    logic        [DATA_WIDTH-1:0] pos_gain;
    logic        [DATA_WIDTH-1:0] vel_gain;
    logic signed [DATA_WIDTH-1:0] ff_torque;

    modport source (
        output valid, measured_pos, target_pos, target_vel, pos_gain, vel_gain, ff_torque,
        input  ready
    );
    modport sink (
        input  valid, measured_pos, target_pos, target_vel, pos_gain, vel_gain, ff_torque,
        output ready
    );
endinterface

/* rtl/jpd_rsp_if.sv */
// Response channel: torque command, velocity estimate and clip flag.
interface jpd_rsp_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive_torque;
    logic signed [DATA_WIDTH-1:0] est_velocity;
    logic                         torque_clipped;

    modport source (
        output valid, drive_torque, est_velocity, torque_clipped,
        input  ready
    );
    modport sink (
        input  valid, drive_torque, est_velocity, torque_clipped,
        output ready
    );
endinterface

/* rtl/jpd_cfg_if.sv */
// Configuration write channel: register index and write data.
interface jpd_cfg_if #(
    parameter int DATA_WIDTH = 32
);
    import jpd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [DATA_WIDTH-1:0] data;

    modport source (
        output valid, addr, data,
        input  ready
    );
    modport sink (
        input  valid, addr, data,
        output ready
    );
endinterface

/* rtl/joint_pd_torque_loop.sv */
// Joint PD torque loop: microcoded sequencer around one shared multiplier.
//
// Usage
//   cmd : one word per control tick (measured position, target position,
//         target velocity, kp, kd, feedforward torque), valid/ready.
//   rsp : one word per accepted command (drive torque, velocity estimate,
//         clip flag), valid/ready, held in an output register.
//   cfg : register writes (index, data), always ready; write only while idle.
// Timing
//   A command is taken in the wait step, then eight microcode steps run the
//   velocity, stiffness and damping products on one multiplier (difference,
//   multiply, round; the stiffness and damping differences overlap the previous
//   round). The response is registered as cmd.ready rises again, so a new
//   command is taken only once the last one has left the output step.
// Reset
//   rst_n clears the step counter, the response valid, the stored last
//   position (to zero) and loads the register defaults.
// Stall
//   When rsp is still full at the output step the sequencer holds there and
//   takes no new command until the response word has been taken.
`include "joint_pd_torque_loop_macros.svh"

module joint_pd_torque_loop
    import jpd_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    jpd_cmd_if.sink    cmd,
    jpd_rsp_if.source  rsp,
    jpd_cfg_if.sink    cfg
);

    // Datapath widths
    localparam int DW  = DATA_WIDTH;
    localparam int AW  = DW + 1;           // signed difference
    localparam int PW  = 2 * DW + 1;       // exact product magnitude
    localparam int RW  = PW - FRAC_BITS;   // rounded magnitude
    localparam int SVW = RW + 1;           // rounded, signed
    localparam int ACW = SVW + 2;          // torque accumulator

    localparam logic [DW-1:0] SMAX_W = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN_W = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [SVW-1:0] SMAX_SV = {{(SVW-DW){1'b0}}, SMAX_W};
    localparam logic signed [SVW-1:0] SMIN_SV = {{(SVW-DW){1'b1}}, SMIN_W};
    localparam logic signed [ACW-1:0] SMAX_AC = {{(ACW-DW){1'b0}}, SMAX_W};
    localparam logic signed [ACW-1:0] SMIN_AC = {{(ACW-DW){1'b1}}, SMIN_W};
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic [DW-1:0] INV_PERIOD_RST = DW'(64'd1000 << FRAC_BITS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                 limits_reg;
    logic signed [DW-1:0] pos_lower_reg;
    logic signed [DW-1:0] pos_upper_reg;
    logic        [DW-2:0] vel_limit_reg;
    logic        [DW-2:0] effort_limit_reg;
    logic        [DW-1:0] inv_period_reg;
    logic signed [DW-1:0] pos_stop_reg;
    logic signed [DW-1:0] vel_stop_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg       <= 1'b1;
            pos_lower_reg    <= SMIN_W;
            pos_upper_reg    <= SMAX_W;
            vel_limit_reg    <= SMAX_W[DW-2:0];
            effort_limit_reg <= SMAX_W[DW-2:0];
            inv_period_reg   <= INV_PERIOD_RST;
            pos_stop_reg     <= SMAX_W;
            vel_stop_reg     <= SMAX_W;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_LIMITS_ENABLED: limits_reg       <= cfg.data[0];
                CFG_POS_LOWER:      pos_lower_reg    <= cfg.data;
                CFG_POS_UPPER:      pos_upper_reg    <= cfg.data;
                CFG_VEL_LIMIT:      vel_limit_reg    <= cfg.data[DW-2:0];
                CFG_EFFORT_LIMIT:   effort_limit_reg <= cfg.data[DW-2:0];
                CFG_INV_PERIOD:     inv_period_reg   <= cfg.data;
                CFG_POS_STOP_CODE:  pos_stop_reg     <= cfg.data;
                CFG_VEL_STOP_CODE:  vel_stop_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: step counter and control store
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctrl_t             uc;
    logic              hold;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic              cmd_fire;
    logic              rsp_put;

    assign uc = ucode(step_reg);

    always_comb
    begin
        case (uc.cond)
            COND_NO_CMD:   hold = !cmd.valid;
            COND_RSP_BUSY: hold = rsp_valid_reg && !rsp.ready;
            default:       hold = 1'b0;
        endcase
        if (hold)
            step_next = step_reg;
        else if (uc.jump)
            step_next = uc.target;
        else
            step_next = step_reg + 1'b1;
    end

    assign cmd.ready = uc.take_cmd;
    assign cmd_fire  = cmd.valid && uc.take_cmd;
    assign rsp_put   = uc.put_rsp && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_WAIT;
        else
            step_reg <= step_next;
    end

    // ------------------------------------------------------------------
    // Command latch: stop codes on the raw targets, then the limit clamps
    // ------------------------------------------------------------------
    logic signed [DW-1:0] q_reg;
    logic signed [DW-1:0] qt_reg;
    logic signed [DW-1:0] vt_reg;
    logic signed [DW-1:0] ff_reg;
    logic        [DW-1:0] kp_reg;
    logic        [DW-1:0] kd_reg;

    logic signed [DW-1:0] qt_clamp;
    logic signed [DW-1:0] vt_clamp;
    logic signed [DW-1:0] ff_clamp;
    logic signed [DW-1:0] vel_hi;
    logic signed [DW-1:0] vel_lo;
    logic signed [DW-1:0] eff_hi;
    logic signed [DW-1:0] eff_lo;

    assign vel_hi = $signed({1'b0, vel_limit_reg});
    assign vel_lo = -vel_hi;
    assign eff_hi = $signed({1'b0, effort_limit_reg});
    assign eff_lo = -eff_hi;

    // Lower bound first, so an inverted range resolves to the lower bound.
    always_comb
    begin
        qt_clamp = cmd.target_pos;
        vt_clamp = cmd.target_vel;
        ff_clamp = cmd.ff_torque;
        if (limits_reg)
        begin
            if (cmd.target_pos < pos_lower_reg)
                qt_clamp = pos_lower_reg;
            else if (cmd.target_pos > pos_upper_reg)
                qt_clamp = pos_upper_reg;
            if (cmd.target_vel < vel_lo)
                vt_clamp = vel_lo;
            else if (cmd.target_vel > vel_hi)
                vt_clamp = vel_hi;
            if (cmd.ff_torque < eff_lo)
                ff_clamp = eff_lo;
            else if (cmd.ff_torque > eff_hi)
                ff_clamp = eff_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            q_reg  <= cmd.measured_pos;
            qt_reg <= qt_clamp;
            vt_reg <= vt_clamp;
            ff_reg <= ff_clamp;
            kp_reg <= (cmd.target_pos == pos_stop_reg) ? '0 : cmd.pos_gain;
            kd_reg <= (cmd.target_vel == vel_stop_reg) ? '0 : cmd.vel_gain;
        end
    end

    // ------------------------------------------------------------------
    // Shared datapath: difference -> magnitude, multiply, round
    // ------------------------------------------------------------------
    logic signed [DW-1:0] last_pos_reg;
    logic signed [DW-1:0] v_reg;
    logic signed [DW-1:0] op_a;
    logic signed [DW-1:0] op_b;
    logic        [DW-1:0] op_gain;
    logic signed [AW-1:0] diff;
    logic        [AW-1:0] mag_reg;
    logic        [DW-1:0] gain_reg;
    logic                 neg_reg;
    logic        [PW-1:0] prod_reg;
    logic        [PW-1:0] rnd_sum;
    logic        [RW-1:0] rnd_mag;
    logic signed [SVW-1:0] rnd_val;
    logic signed [DW-1:0] v_sat;
    logic signed [ACW-1:0] rnd_ext;
    logic signed [ACW-1:0] acc_reg;
    logic signed [ACW-1:0] acc_next;

    always_comb
    begin
        case (uc.diff_sel)
            DIFF_VEL:
            begin
                op_a    = q_reg;
                op_b    = last_pos_reg;
                op_gain = inv_period_reg;
            end
            DIFF_POS:
            begin
                op_a    = qt_reg;
                op_b    = q_reg;
                op_gain = kp_reg;
            end
            DIFF_DAMP:
            begin
                op_a    = vt_reg;
                op_b    = v_reg;
                op_gain = kd_reg;
            end
            default:
            begin
                op_a    = q_reg;
                op_b    = q_reg;
                op_gain = '0;
            end
        endcase
    end

    assign diff = $signed({op_a[DW-1], op_a}) - $signed({op_b[DW-1], op_b});

    // Latch magnitude, sign and gain for the next multiply
    always_ff @(posedge clk)
    begin
        if (uc.diff_sel != DIFF_NONE)
        begin
            mag_reg  <= diff[AW-1] ? (~diff + 1'b1) : diff;
            neg_reg  <= diff[AW-1];
            gain_reg <= op_gain;
        end
        if (uc.mul_en)
            prod_reg <= mag_reg * gain_reg;
    end

    // Round half away from zero on the magnitude, then restore the sign
    assign rnd_sum = prod_reg + HALF;
    assign rnd_mag = rnd_sum[PW-1:FRAC_BITS];
    assign rnd_val = neg_reg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});
    assign rnd_ext = {{(ACW-SVW){rnd_val[SVW-1]}}, rnd_val};

    always_comb
    begin
        if (rnd_val > SMAX_SV)
            v_sat = SMAX_W;
        else if (rnd_val < SMIN_SV)
            v_sat = SMIN_W;
        else
            v_sat = rnd_val[DW-1:0];
    end

    always_comb
    begin
        case (uc.rnd_op)
            RND_LOAD: acc_next = rnd_ext + $signed({{(ACW-DW){ff_reg[DW-1]}}, ff_reg});
            RND_ADD:  acc_next = acc_reg + rnd_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (uc.rnd_op == RND_VEL)
            v_reg <= v_sat;
    end

    // Keep the measured position once the velocity product is done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_pos_reg <= '0;
        else if (uc.rnd_op == RND_VEL)
            last_pos_reg <= q_reg;
    end

    // ------------------------------------------------------------------
    // Output clamp and response register
    // ------------------------------------------------------------------
    logic signed [ACW-1:0] tq_clamp;
    logic signed [ACW-1:0] eff_hi_ac;
    logic signed [DW-1:0]  rsp_torque_reg;
    logic signed [DW-1:0]  rsp_vel_reg;
    logic                  rsp_clip_reg;

    assign eff_hi_ac = $signed({{(ACW-DW+1){1'b0}}, effort_limit_reg});

    always_comb
    begin
        tq_clamp = acc_reg;
        if (limits_reg)
        begin
            if (tq_clamp < -eff_hi_ac)
                tq_clamp = -eff_hi_ac;
            else if (tq_clamp > eff_hi_ac)
                tq_clamp = eff_hi_ac;
        end
        if (tq_clamp < SMIN_AC)
            tq_clamp = SMIN_AC;
        else if (tq_clamp > SMAX_AC)
            tq_clamp = SMAX_AC;
    end

    always_comb
    begin
        if (rsp_put)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rsp_put)
        begin
            rsp_torque_reg <= tq_clamp[DW-1:0];
            rsp_vel_reg    <= v_reg;
            rsp_clip_reg   <= (tq_clamp != acc_reg);
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.drive_torque   = rsp_torque_reg;
    assign rsp.est_velocity   = rsp_vel_reg;
    assign rsp.torque_clipped = rsp_clip_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `JPD_ASSERT_NEXT(a_cmd_starts_program, cmd.valid && cmd.ready,
        step_reg == ST_VEL_DIFF, "accepted command did not start the program")
    `JPD_ASSERT_NOW(a_ready_only_waiting, cmd.ready, step_reg == ST_WAIT,
        "command ready outside the wait step")
    `JPD_ASSERT_NOW(a_rsp_from_output_step, $rose(rsp_valid_reg),
        $past(step_reg) == ST_OUT, "response raised outside the output step")
    `JPD_ASSERT_NEXT(a_busy_holds_output_step,
        step_reg == ST_OUT && rsp_valid_reg && !rsp.ready, step_reg == ST_OUT,
        "sequencer left the output step while response was full")

endmodule

/* verif/jpd_tb_pkg.sv */
`timescale 1ns / 100ps
// Word types and the torque tracker (predictor plus expected-word store) for the testbench.
package jpd_tb_pkg;
    import jpd_pkg::*;

    localparam int     WORD_W   = 32;
    localparam int     FRAC_W   = 16;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct {
        logic [WORD_W-1:0] measured_pos;
        logic [WORD_W-1:0] target_pos;
        logic [WORD_W-1:0] target_vel;
        logic [WORD_W-1:0] pos_gain;
        logic [WORD_W-1:0] vel_gain;
        logic [WORD_W-1:0] ff_torque;
    } tick_cmd_t;

    typedef struct {
        logic [WORD_W-1:0] drive_torque;
        logic [WORD_W-1:0] est_velocity;
        logic              torque_clipped;
    } torque_word_t;

    typedef struct {
        logic              limits_enabled;
        logic [WORD_W-1:0] pos_lower;
        logic [WORD_W-1:0] pos_upper;
        logic [WORD_W-1:0] vel_limit;
        logic [WORD_W-1:0] effort_limit;
        logic [WORD_W-1:0] inv_period;
        logic [WORD_W-1:0] pos_stop_code;
        logic [WORD_W-1:0] vel_stop_code;
    } loop_settings_t;

    class torque_tracker;
        torque_word_t      expected_words[$];
        int unsigned       mismatches;
        int unsigned       matched;
        logic              limits_on;
        longint            pos_lo;
        longint            pos_hi;
        longint            vel_lim;
        longint            eff_lim;
        longint            pos_stop;
        longint            vel_stop;
        longint            last_pos;
        logic [WORD_W-1:0] inv_period;

        function new();
            limits_on  = 1'b1;
            pos_lo     = WORD_MIN;
            pos_hi     = WORD_MAX;
            vel_lim    = WORD_MAX;
            eff_lim    = WORD_MAX;
            inv_period = 32'h03E8_0000;
            pos_stop   = WORD_MAX;
            vel_stop   = WORD_MAX;
            last_pos   = 0;
            mismatches = 0;
            matched    = 0;
        endfunction

        // Lower bound wins when the bounds are inverted.
        static function longint clip_to(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        // Exact product, magnitude rounded half away from zero, sign put back.
        static function longint scale_round(longint diff, logic [WORD_W-1:0] gain);
            logic [65:0] mag;
            logic [65:0] prod;
            longint      r;
            mag  = (diff < 0) ? 66'(-diff) : 66'(diff);
            prod = mag * 66'(gain);
            prod = (prod + (66'd1 << (FRAC_W - 1))) >> FRAC_W;
            r    = longint'(prod[63:0]);
            return (diff < 0) ? -r : r;
        endfunction

        function void write_register(logic [CFG_ADDR_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                CFG_LIMITS_ENABLED: limits_on  = data[0];
                CFG_POS_LOWER:      pos_lo     = longint'($signed(data));
                CFG_POS_UPPER:      pos_hi     = longint'($signed(data));
                CFG_VEL_LIMIT:      vel_lim    = longint'({33'd0, data[WORD_W-2:0]});
                CFG_EFFORT_LIMIT:   eff_lim    = longint'({33'd0, data[WORD_W-2:0]});
                CFG_INV_PERIOD:     inv_period = data;
                CFG_POS_STOP_CODE:  pos_stop   = longint'($signed(data));
                CFG_VEL_STOP_CODE:  vel_stop   = longint'($signed(data));
                default: ;
            endcase
        endfunction

        function void predict_torque(tick_cmd_t c);
            longint            q;
            longint            qt;
            longint            vt;
            longint            ff;
            longint            vel;
            longint            sum;
            longint            tq;
            logic [WORD_W-1:0] kp;
            logic [WORD_W-1:0] kd;
            torque_word_t      w;
            q  = longint'($signed(c.measured_pos));
            qt = longint'($signed(c.target_pos));
            vt = longint'($signed(c.target_vel));
            ff = longint'($signed(c.ff_torque));
            kp = c.pos_gain;
            kd = c.vel_gain;
            // stop codes compare against the raw targets
            if (qt == pos_stop)
                kp = '0;
            if (vt == vel_stop)
                kd = '0;
            if (limits_on)
            begin
                qt = clip_to(qt, pos_lo, pos_hi);
                vt = clip_to(vt, -vel_lim, vel_lim);
                ff = clip_to(ff, -eff_lim, eff_lim);
            end
            vel = clip_to(scale_round(q - last_pos, inv_period), WORD_MIN, WORD_MAX);
            sum = scale_round(qt - q, kp) + scale_round(vt - vel, kd) + ff;
            tq  = sum;
            if (limits_on)
                tq = clip_to(tq, -eff_lim, eff_lim);
            tq = clip_to(tq, WORD_MIN, WORD_MAX);
            last_pos = q;
            w.drive_torque   = tq[WORD_W-1:0];
            w.est_velocity   = vel[WORD_W-1:0];
            w.torque_clipped = (tq != sum);
            expected_words.push_back(w);
        endfunction

        function void check_field(string name, logic [WORD_W-1:0] exp_v,
                                  logic [WORD_W-1:0] act_v);
            if (exp_v !== act_v)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void compare_torque(torque_word_t got);
            torque_word_t w;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: response with nothing outstanding, expected none actual %h %h %b",
                         $time, got.drive_torque, got.est_velocity, got.torque_clipped);
                return;
            end
            w = expected_words.pop_front();
            check_field("drive_torque", w.drive_torque, got.drive_torque);
            check_field("est_velocity", w.est_velocity, got.est_velocity);
            check_field("torque_clipped", 32'(w.torque_clipped), 32'(got.torque_clipped));
            matched++;
        endfunction

        function int unsigned outstanding();
            return expected_words.size();
        endfunction

        function void check_drained();
            if (expected_words.size() != 0)
            begin
                mismatches++;
                $display("%0t: responses missing, expected %0d more actual 0",
                         $time, expected_words.size());
            end
        endfunction
    endclass

endpackage

/* verif/tb_joint_pd_torque_loop.sv */
`timescale 1ns / 100ps
// Top-level testbench of the joint PD torque loop: stimulus, handshakes and verdict.
module tb_joint_pd_torque_loop;
    import jpd_pkg::*;
    import jpd_tb_pkg::*;

    localparam int                WATCHDOG_LIMIT = 2000;
    // leave room after a tick for a stalled response word
    localparam int                SETTLE_CYCLES  = 24;
    localparam int                PHASE_TICKS    = 150;
    localparam logic [WORD_W-1:0] ONE            = 32'h0001_0000;
    localparam logic [WORD_W-1:0] W_MAX          = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] W_MIN          = 32'h8000_0000;
    localparam logic [WORD_W-1:0] W_ALL          = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;

    jpd_cmd_if #(.DATA_WIDTH(WORD_W)) cmd_bus ();
    jpd_rsp_if #(.DATA_WIDTH(WORD_W)) rsp_bus ();
    jpd_cfg_if #(.DATA_WIDTH(WORD_W)) cfg_bus ();

    joint_pd_torque_loop #(
        .DATA_WIDTH (WORD_W),
        .FRAC_BITS  (FRAC_W)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    torque_tracker     book;
    int                idle_pct      = 36;
    int unsigned       quiet_cycles  = 0;
    int unsigned       ticks_sent    = 0;
    int unsigned       writes_done   = 0;
    int unsigned       settings_used = 0;
    logic [WORD_W-1:0] last_measured = '0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Response side: check each word taken, then stall at random for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            book.compare_torque('{rsp_bus.drive_torque, rsp_bus.est_velocity,
                                  rsp_bus.torque_clipped});
        rsp_bus.ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end

    // Watchdog: end the run when no channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic tick_cmd_t make_tick(logic [WORD_W-1:0] m, logic [WORD_W-1:0] qt,
                                            logic [WORD_W-1:0] vt, logic [WORD_W-1:0] kp,
                                            logic [WORD_W-1:0] kd, logic [WORD_W-1:0] ff);
        tick_cmd_t c;
        c.measured_pos = m;
        c.target_pos   = qt;
        c.target_vel   = vt;
        c.pos_gain     = kp;
        c.vel_gain     = kd;
        c.ff_torque    = ff;
        return c;
    endfunction

    function automatic loop_settings_t make_settings(logic lim, logic [WORD_W-1:0] lo,
                                                     logic [WORD_W-1:0] hi,
                                                     logic [WORD_W-1:0] vel,
                                                     logic [WORD_W-1:0] eff,
                                                     logic [WORD_W-1:0] inv,
                                                     logic [WORD_W-1:0] ps,
                                                     logic [WORD_W-1:0] vs);
        loop_settings_t s;
        s.limits_enabled = lim;
        s.pos_lower      = lo;
        s.pos_upper      = hi;
        s.vel_limit      = vel;
        s.effort_limit   = eff;
        s.inv_period     = inv;
        s.pos_stop_code  = ps;
        s.vel_stop_code  = vs;
        return s;
    endfunction

    // Uniform value in [-span, span], wrapped to a word.
    function automatic logic [WORD_W-1:0] near_zero(int unsigned span);
        logic [WORD_W-1:0] v;
        v = $urandom_range(span * 2);
        return v - span;
    endfunction

    function automatic logic [WORD_W-1:0] extreme_word();
        case ($urandom_range(3))
            0:       return W_MIN;
            1:       return W_MAX;
            2:       return '0;
            default: return W_ALL;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_gain();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return $urandom;
        if (pick < 8)
            return $urandom_range(32'h0020_0000);
        return (pick == 8) ? '0 : W_ALL;
    endfunction

    // Mostly plausible motion around the last position, with wide and extreme words mixed in;
    // aim targets at the stop codes and clamp bounds often enough to hit them.
    function automatic tick_cmd_t random_tick(loop_settings_t s);
        tick_cmd_t   c;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
            c.measured_pos = last_measured + near_zero(32'h0000_4000);
        else if (pick < 7)
            c.measured_pos = $urandom;
        else if (pick == 7)
            c.measured_pos = near_zero(32'h0010_0000);
        else
            c.measured_pos = extreme_word();

        pick = $urandom_range(9);
        if (pick < 4)
            c.target_pos = $urandom;
        else if (pick < 7)
            c.target_pos = near_zero(32'h0020_0000);
        else if (pick == 7)
            c.target_pos = s.pos_stop_code;
        else if (pick == 8)
            c.target_pos = s.pos_lower + near_zero(4);
        else
            c.target_pos = s.pos_upper + near_zero(4);

        pick = $urandom_range(9);
        if (pick < 4)
            c.target_vel = $urandom;
        else if (pick < 7)
            c.target_vel = near_zero(32'h0020_0000);
        else if (pick == 7)
            c.target_vel = s.vel_stop_code;
        else if (pick == 8)
            c.target_vel = {1'b0, s.vel_limit[WORD_W-2:0]} + near_zero(4);
        else
            c.target_vel = -{1'b0, s.vel_limit[WORD_W-2:0]} + near_zero(4);

        c.pos_gain = random_gain();
        c.vel_gain = random_gain();

        pick = $urandom_range(9);
        if (pick < 4)
            c.ff_torque = $urandom;
        else if (pick < 7)
            c.ff_torque = near_zero(32'h0020_0000);
        else if (pick == 7)
            c.ff_torque = extreme_word();
        else if (pick == 8)
            c.ff_torque = {1'b0, s.effort_limit[WORD_W-2:0]} + near_zero(4);
        else
            c.ff_torque = -{1'b0, s.effort_limit[WORD_W-2:0]} + near_zero(4);
        return c;
    endfunction

    // Settings flavours: reset values, typical, wild, limits off, all zero, inverted bounds.
    function automatic loop_settings_t random_settings(int flavour);
        logic [WORD_W-1:0] edge_pos;
        edge_pos = $urandom_range(ONE, 32'h0008_0000);
        case (flavour)
            0: return make_settings(1'b1, W_MIN, W_MAX, W_MAX, W_MAX, 32'h03E8_0000,
                                    W_MAX, W_MAX);
            1: return make_settings(1'b1, -$urandom_range(ONE, 32'h0028_0000),
                                    $urandom_range(ONE, 32'h0028_0000),
                                    $urandom_range(32'h0014_0000),
                                    $urandom_range(32'h0064_0000),
                                    $urandom_range(32'h0064_0000, 32'h07D0_0000),
                                    near_zero(32'h0008_0000), near_zero(32'h0008_0000));
            2: return make_settings(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom);
            3: return make_settings(1'b0, $urandom, $urandom, $urandom, $urandom, W_ALL,
                                    $urandom, $urandom);
            4: return make_settings(1'b1, '0, '0, '0, '0, '0, W_MIN, W_MIN);
            default: return make_settings(1'b1, edge_pos, -edge_pos, W_ALL, W_ALL,
                                          32'h03E8_0000, near_zero(ONE), near_zero(ONE));
        endcase
    endfunction

    // Present one register write and hold until it is taken; the caller drops valid.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.addr  <= idx;
        cfg_bus.data  <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        book.write_register(idx, data);
        writes_done++;
    endtask

    // Write every register; only called with nothing outstanding.
    task automatic apply_settings(input loop_settings_t s);
        write_reg(CFG_LIMITS_ENABLED, {31'd0, s.limits_enabled});
        write_reg(CFG_POS_LOWER,      s.pos_lower);
        write_reg(CFG_POS_UPPER,      s.pos_upper);
        write_reg(CFG_VEL_LIMIT,      s.vel_limit);
        write_reg(CFG_EFFORT_LIMIT,   s.effort_limit);
        write_reg(CFG_INV_PERIOD,     s.inv_period);
        write_reg(CFG_POS_STOP_CODE,  s.pos_stop_code);
        write_reg(CFG_VEL_STOP_CODE,  s.vel_stop_code);
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    // Offer one tick word after a random gap; valid stays high when there is no gap, so it
    // is never lowered and raised in the same step.
    task automatic send_tick(input tick_cmd_t c);
        int gap;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.measured_pos <= c.measured_pos;
        cmd_bus.target_pos   <= c.target_pos;
        cmd_bus.target_vel   <= c.target_vel;
        cmd_bus.pos_gain     <= c.pos_gain;
        cmd_bus.vel_gain     <= c.vel_gain;
        cmd_bus.ff_torque    <= c.ff_torque;
        do @(posedge clk); while (!cmd_bus.ready);
        book.predict_torque(c);
        last_measured = c.measured_pos;
        ticks_sent++;
    endtask

    // Drop valid and hold until every expected word is back, then let the pipe settle.
    task automatic drain_ticks();
        cmd_bus.valid <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        // reset values: velocity saturation both ways, full gains, stop codes at max
        send_tick(make_tick('0, '0, '0, '0, '0, '0));
        send_tick(make_tick(ONE, 2 * ONE, '0, ONE, '0, '0));
        send_tick(make_tick(W_MAX, W_MIN, W_MIN, W_ALL, W_ALL, W_MIN));
        send_tick(make_tick(W_MIN, W_MAX, W_MAX, W_ALL, W_ALL, W_MAX));
        send_tick(make_tick(W_MIN, W_MAX - 1, -ONE, ONE, ONE, '0));
        drain_ticks();

        // limits off: half-LSB rounding of the velocity, torque saturates to the word range
        apply_settings(make_settings(1'b0, '0, '0, '0, '0, 32'h0000_8000, '0, '0));
        send_tick(make_tick(W_MIN + 1, '0, '0, W_ALL, W_ALL, 32'd5));
        send_tick(make_tick(W_MIN, W_MAX, 32'd1, W_ALL, ONE, '0));
        send_tick(make_tick(W_MAX, W_MIN, W_MIN, W_ALL, W_ALL, W_MIN));
        send_tick(make_tick(W_MAX, 32'd1, W_ALL, 32'h0000_8000, 32'h0000_8000, '0));
        drain_ticks();

        // inverted position bounds, zero velocity and effort limits, largest reciprocal period
        apply_settings(make_settings(1'b1, 5 * ONE, -5 * ONE, '0, '0, W_ALL,
                                     32'h1234_5678, 32'hEDCB_A988));
        send_tick(make_tick('0, -8 * ONE, 3 * ONE, ONE, ONE, ONE));
        send_tick(make_tick(ONE, 7 * ONE, 32'hEDCB_A988, 2 * ONE, W_ALL, '0));
        send_tick(make_tick(ONE, 32'h1234_5678, -2 * ONE, W_ALL, '0, '0));
        drain_ticks();

        // ordinary limits: range clamps, feedforward clamp, stop codes at min, rounding sign
        apply_settings(make_settings(1'b1, -10 * ONE, 10 * ONE, 2 * ONE, 5 * ONE,
                                     32'h03E8_0000, W_MIN, W_MIN));
        send_tick(make_tick('0, 3 * ONE, ONE, ONE, '0, ONE));
        send_tick(make_tick('0, 20 * ONE, 9 * ONE, ONE, ONE, -9 * ONE));
        send_tick(make_tick(32'h0000_0100, W_MIN, W_MIN, W_ALL, W_ALL, W_MAX));
        send_tick(make_tick(-ONE, -11 * ONE, -3 * ONE, 3 * ONE, 32'h0000_4000, -2 * ONE));
        send_tick(make_tick(-ONE, '0, '0, 32'h0000_8000, 32'h0000_8000, '0));
        send_tick(make_tick(W_ALL, '0, '0, 32'h0000_8000, '0, '0));
        send_tick(make_tick(32'd1, '0, '0, 32'h0000_8000, '0, '0));
        drain_ticks();
    endtask

    // One block of random ticks under one setting; optionally pause halfway until all is back.
    task automatic run_phase(input int flavour, input bit no_idle, input bit pause_midway);
        loop_settings_t s;
        s = random_settings(flavour);
        apply_settings(s);
        idle_pct = no_idle ? 0 : 36;
        for (int i = 0; i < PHASE_TICKS; i++)
        begin
            if (pause_midway && i == PHASE_TICKS / 2)
                drain_ticks();
            send_tick(random_tick(s));
        end
        drain_ticks();
        idle_pct = 36;
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        cmd_bus.valid        <= 1'b0;
        cmd_bus.measured_pos <= '0;
        cmd_bus.target_pos   <= '0;
        cmd_bus.target_vel   <= '0;
        cmd_bus.pos_gain     <= '0;
        cmd_bus.vel_gain     <= '0;
        cmd_bus.ff_torque    <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.addr         <= CFG_LIMITS_ENABLED;
        cfg_bus.data         <= '0;
        book = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // typical first with a mid-phase pause, then wild, limits off, a stretch with
        // no idling on either side, all-zero limits, inverted bounds, the reset values and wild again
        run_phase(1, 1'b0, 1'b1);
        run_phase(2, 1'b0, 1'b0);
        run_phase(3, 1'b0, 1'b0);
        run_phase(1, 1'b1, 1'b0);
        run_phase(4, 1'b0, 1'b0);
        run_phase(5, 1'b0, 1'b0);
        run_phase(0, 1'b0, 1'b0);
        run_phase(2, 1'b0, 1'b0);

        book.check_drained();
        $display("Run covered %0d ticks and %0d checked responses under %0d settings",
                 ticks_sent, book.matched, settings_used);
        $display("(%0d register writes: clamps on and off, stop codes, saturation, rounding)",
                 writes_done);
        if (book.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
